/* design/psb_pkg.sv */
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types, codes and constants of the path safety bubble generator.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int OBSTACLE_DEPTH_DEF = 256;
    localparam int PATH_DEPTH_DEF     = 64;
    localparam int SHIFT_TRIES_DEF    = 10;

    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int CFG_IDX_W = 1;

    // operation codes
    localparam logic [1:0] OP_LOAD_OBST = 2'd0;
    localparam logic [1:0] OP_LOAD_PATH = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_RADIUS = 1'd1;

    localparam logic [RAD_W-1:0] MAX_RADIUS_RST = 31'd131072;
    localparam logic [RAD_W-1:0] ACC_RADIUS_RST = 31'd32768;
    localparam logic [RAD_W-1:0] RADIUS_SAT     = 31'h7FFF_FFFF;

    // floor(m / 5) == (m * RECIP5) >> 34 for any 32-bit m
    localparam logic [31:0] RECIP5      = 32'hCCCC_CCCD;
    localparam int          RECIP5_SHR  = 34;
    localparam int          SQRT_STEPS  = 32;

    // multiplier operand select
    localparam logic [1:0] MUL_UX = 2'd0;
    localparam logic [1:0] MUL_UY = 2'd1;
    localparam logic [1:0] MUL_DX = 2'd2;
    localparam logic [1:0] MUL_DY = 2'd3;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]          radius;
        logic                      last_bubble;
        logic                      error;
    } out_item_t;

    typedef struct packed {
        logic       ld_obst;
        logic       ld_path;
        logic       walk_init;
        logic       p_latch;
        logic       scan_clr;
        logic       scan_inc;
        logic       d_load;
        logic       d_src_path;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_load;
        logic       sq_start;
        logic       near_upd;
        logic       clamp;
        logic       j_inc;
        logic       idx_from_j;
        logic       idx_max;
        logic       path_sel_j;
        logic       obst_sel_k;
        logic       div_load;
        logic       ddx_load;
        logic       ddy_load;
        logic       shift_init;
        logic       step;
        logic       trial_load;
        logic       eval;
        logic       out_load;
        logic       out_err;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic sq_busy;
        logic scan_last;
        logic jump_hit;
        logic j_end;
        logic small_r;
        logic box_hit;
        logic ev_accept;
        logic s_last;
        logic out_free;
        logic done_flag;
    } dp_sts_t;

endpackage

/* design/path_safety_bubble_generator.sv */
// ----------------------------------------------------------------------------
// path_safety_bubble_generator
// Safety bubbles along a loaded path, sized by the nearest loaded obstacle.
// ----------------------------------------------------------------------------
// Loads of obstacle and path points are taken one beat per cycle. A start beat
// walks the path and returns one result beat per bubble, the last one flagged.
// The time is set by the shared distance unit: each point-to-point distance is a
// registered memory read, two squarings on one 32x32 multiplier, then a 32-step
// bit-serial square root. A bubble costs one nearest scan over the obstacles,
// the jump ahead (one distance per skipped point, plus a bound check) and, for a
// small bubble, up to SHIFT_TRIES steps of a box scan plus a nearest scan. No
// input beat is taken until the run's last result has been loaded into the
// output register.
// ----------------------------------------------------------------------------
module path_safety_bubble_generator
    import psb_pkg::*;
#(
    parameter int OBSTACLE_DEPTH = OBSTACLE_DEPTH_DEF,
    parameter int PATH_DEPTH     = PATH_DEPTH_DEF,
    parameter int SHIFT_TRIES    = SHIFT_TRIES_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAD_W-1:0]     cfg_wdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    psb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .operation (s_data.operation),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    psb_datapath #(
        .OBSTACLE_DEPTH (OBSTACLE_DEPTH),
        .PATH_DEPTH     (PATH_DEPTH),
        .SHIFT_TRIES    (SHIFT_TRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

/* design/psb_isqrt.sv */
// ----------------------------------------------------------------------------
// psb_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module psb_isqrt
    import psb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    localparam int REM_W = 33;
    localparam int CNT_W = $clog2(SQRT_STEPS);

    logic [63:0]      rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [31:0]      root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W+1:0] rem_next;

    assign rem_sh   = {rem_reg, rad_reg[63:62]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_next = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= rem_next[REM_W-1:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* design/psb_datapath.sv */
// ----------------------------------------------------------------------------
// psb_datapath
// Point memories, distance and shift arithmetic, result register.
// ----------------------------------------------------------------------------
module psb_datapath
    import psb_pkg::*;
#(
    parameter int OBSTACLE_DEPTH = OBSTACLE_DEPTH_DEF,
    parameter int PATH_DEPTH     = PATH_DEPTH_DEF,
    parameter int SHIFT_TRIES    = SHIFT_TRIES_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  in_item_t             in_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAD_W-1:0]     cfg_wdata,
    input  logic                 m_ready,
    output logic                 m_valid,
    output out_item_t            m_data
);

    localparam int OAW = (OBSTACLE_DEPTH > 1) ? $clog2(OBSTACLE_DEPTH) : 1;
    localparam int OCW = $clog2(OBSTACLE_DEPTH + 1);
    localparam int PAW = $clog2(PATH_DEPTH);
    localparam int PCW = $clog2(PATH_DEPTH + 1);
    localparam int SW  = (SHIFT_TRIES > 1) ? $clog2(SHIFT_TRIES) : 1;

    logic signed [COORD_W-1:0] obst_x_mem [OBSTACLE_DEPTH];
    logic signed [COORD_W-1:0] obst_y_mem [OBSTACLE_DEPTH];
    logic signed [COORD_W-1:0] path_x_mem [PATH_DEPTH];
    logic signed [COORD_W-1:0] path_y_mem [PATH_DEPTH];

    logic signed [COORD_W-1:0] obx_q_reg, oby_q_reg, pax_q_reg, pay_q_reg;

    logic [OCW-1:0]            ocnt_reg;
    logic [PCW-1:0]            pcnt_reg;
    logic [RAD_W-1:0]          maxr_reg, accr_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg, tx_reg, ty_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, nx_reg, ny_reg;
    logic signed [COORD_W-1:0] ddx_reg, ddy_reg;
    logic                      done_reg;
    logic [OAW-1:0]            i_reg, k_reg;
    logic [PAW-1:0]            idx_reg;
    logic [PCW-1:0]            j_reg;
    logic [RAD_W-1:0]          nmin_reg, r_reg, rad_reg, trial_reg, best_reg;
    logic [RAD_W-1:0]          ux_reg, uy_reg;
    logic                      big_reg;
    logic [31:0]               mx_reg, my_reg;
    logic                      sx_reg, sy_reg;
    logic [63:0]               prod_reg, acc_reg;
    logic [SW-1:0]             s_reg;
    logic                      m_valid_reg;
    out_item_t                 m_data_reg;

    logic [OAW-1:0]            obst_addr;
    logic [PAW-1:0]            path_addr;
    logic [PCW-1:0]            maxi;
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [COORD_W:0]   dx, dy, adx, ady, vx, vy, avx, avy;
    logic [31:0]               mul_a, mul_b;
    logic [31:0]               sq_root;
    logic [RAD_W-1:0]          pt_dist;
    logic [RAD_W-1:0]          r_cl;
    logic signed [COORD_W:0]   sum_x, sum_y;
    logic signed [COORD_W-1:0] nx_next, ny_next;
    logic signed [COORD_W-1:0] lx, hx, ly, hy;
    logic [29:0]               quo;
    logic                      ev_ge, ev_gt;
    logic                      sq_busy;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W:0] v);
        logic signed [COORD_W-1:0] res;
        if (v[COORD_W] != v[COORD_W-1]) begin
            res = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    assign maxi      = pcnt_reg - 1'b1;
    assign obst_addr = cmd.obst_sel_k ? k_reg : i_reg;
    assign path_addr = cmd.path_sel_j ? j_reg[PAW-1:0] : idx_reg;

    // point memories
    always_ff @(posedge aclk) begin
        if (cmd.ld_obst && ocnt_reg < OCW'(OBSTACLE_DEPTH)) begin
            obst_x_mem[ocnt_reg[OAW-1:0]] <= in_data.coord_x;
            obst_y_mem[ocnt_reg[OAW-1:0]] <= in_data.coord_y;
        end
        obx_q_reg <= obst_x_mem[obst_addr];
        oby_q_reg <= obst_y_mem[obst_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_path && pcnt_reg < PCW'(PATH_DEPTH)) begin
            path_x_mem[pcnt_reg[PAW-1:0]] <= in_data.coord_x;
            path_y_mem[pcnt_reg[PAW-1:0]] <= in_data.coord_y;
        end
        pax_q_reg <= path_x_mem[path_addr];
        pay_q_reg <= path_y_mem[path_addr];
    end

    // counts and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= '0;
            pcnt_reg <= '0;
            maxr_reg <= MAX_RADIUS_RST;
            accr_reg <= ACC_RADIUS_RST;
        end else begin
            if (cmd.ld_obst && ocnt_reg < OCW'(OBSTACLE_DEPTH)) begin
                ocnt_reg <= ocnt_reg + 1'b1;
            end
            if (cmd.ld_path && pcnt_reg < PCW'(PATH_DEPTH)) begin
                pcnt_reg <= pcnt_reg + 1'b1;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MAX_RADIUS: maxr_reg <= cfg_wdata;
                    REG_ACC_RADIUS: accr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // distance operands: memory point against the target point
    assign ax  = cmd.d_src_path ? pax_q_reg : obx_q_reg;
    assign ay  = cmd.d_src_path ? pay_q_reg : oby_q_reg;
    assign dx  = {ax[COORD_W-1], ax} - {tx_reg[COORD_W-1], tx_reg};
    assign dy  = {ay[COORD_W-1], ay} - {ty_reg[COORD_W-1], ty_reg};
    assign adx = dx[COORD_W] ? -dx : dx;
    assign ady = dy[COORD_W] ? -dy : dy;

    // offset of the point from its nearest obstacle
    assign vx  = {px_reg[COORD_W-1], px_reg} - {obx_q_reg[COORD_W-1], obx_q_reg};
    assign vy  = {py_reg[COORD_W-1], py_reg} - {oby_q_reg[COORD_W-1], oby_q_reg};
    assign avx = vx[COORD_W] ? -vx : vx;
    assign avy = vy[COORD_W] ? -vy : vy;

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_UX: begin mul_a = {1'b0, ux_reg}; mul_b = {1'b0, ux_reg}; end
            MUL_UY: begin mul_a = {1'b0, uy_reg}; mul_b = {1'b0, uy_reg}; end
            MUL_DX: begin mul_a = mx_reg;         mul_b = RECIP5;         end
            MUL_DY: begin mul_a = my_reg;         mul_b = RECIP5;         end
            default: begin mul_a = '0;            mul_b = '0;             end
        endcase
    end

    psb_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sq_start),
        .radicand (acc_reg + prod_reg),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    assign pt_dist = (big_reg || sq_root[31]) ? RADIUS_SAT : sq_root[RAD_W-1:0];
    assign r_cl    = (nmin_reg > maxr_reg) ? maxr_reg : nmin_reg;
    assign quo     = prod_reg[63:RECIP5_SHR];

    assign sum_x   = {nx_reg[COORD_W-1], nx_reg} + {ddx_reg[COORD_W-1], ddx_reg};
    assign sum_y   = {ny_reg[COORD_W-1], ny_reg} + {ddy_reg[COORD_W-1], ddy_reg};
    assign nx_next = sat32(sum_x);
    assign ny_next = sat32(sum_y);

    assign lx = (px_reg < nx_reg) ? px_reg : nx_reg;
    assign hx = (px_reg < nx_reg) ? nx_reg : px_reg;
    assign ly = (py_reg < ny_reg) ? py_reg : ny_reg;
    assign hy = (py_reg < ny_reg) ? ny_reg : py_reg;

    assign ev_ge = trial_reg >= best_reg;
    assign ev_gt = trial_reg > accr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.p_latch) begin
            px_reg   <= pax_q_reg;
            py_reg   <= pay_q_reg;
            tx_reg   <= pax_q_reg;
            ty_reg   <= pay_q_reg;
            done_reg <= (PCW'(idx_reg) == maxi);
        end
        if (cmd.scan_clr) begin
            i_reg <= '0;
        end else if (cmd.scan_inc) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.d_load) begin
            ux_reg  <= adx[RAD_W-1:0];
            uy_reg  <= ady[RAD_W-1:0];
            big_reg <= (|adx[COORD_W:RAD_W]) || (|ady[COORD_W:RAD_W]);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg;
        end
        if (cmd.near_upd && (i_reg == '0 || pt_dist < nmin_reg)) begin
            nmin_reg <= pt_dist;
            k_reg    <= i_reg;
        end
        if (cmd.clamp) begin
            r_reg   <= r_cl;
            rad_reg <= r_cl;
            cx_reg  <= px_reg;
            cy_reg  <= py_reg;
            j_reg   <= PCW'(idx_reg) + 1'b1;
        end
        if (cmd.j_inc) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.idx_from_j) begin
            idx_reg <= j_reg[PAW-1:0];
        end else if (cmd.idx_max) begin
            idx_reg <= maxi[PAW-1:0];
        end else if (cmd.walk_init) begin
            // every start walks from the first point
            idx_reg <= '0;
        end
        if (cmd.div_load) begin
            mx_reg <= avx[31:0];
            my_reg <= avy[31:0];
            sx_reg <= vx[COORD_W];
            sy_reg <= vy[COORD_W];
        end
        if (cmd.ddx_load) begin
            ddx_reg <= sx_reg ? -{2'b00, quo} : {2'b00, quo};
        end
        if (cmd.ddy_load) begin
            ddy_reg <= sy_reg ? -{2'b00, quo} : {2'b00, quo};
        end
        if (cmd.shift_init) begin
            nx_reg    <= px_reg;
            ny_reg    <= py_reg;
            trial_reg <= '0;
            best_reg  <= '0;
            s_reg     <= '0;
        end
        if (cmd.step) begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            tx_reg <= nx_next;
            ty_reg <= ny_next;
        end
        if (cmd.trial_load) begin
            trial_reg <= nmin_reg;
        end
        if (cmd.eval) begin
            s_reg <= s_reg + 1'b1;
            if (ev_ge) begin
                best_reg <= trial_reg;
                if (ev_gt) begin
                    rad_reg <= trial_reg;
                    cx_reg  <= nx_reg;
                    cy_reg  <= ny_reg;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_err) begin
                m_data_reg <= '{center_x: '0, center_y: '0, radius: '0,
                                last_bubble: 1'b1, error: 1'b1};
            end else begin
                m_data_reg <= '{center_x: cx_reg, center_y: cy_reg, radius: rad_reg,
                                last_bubble: done_reg, error: 1'b0};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.empty     = (ocnt_reg == '0) || (pcnt_reg == '0);
    assign sts.sq_busy   = sq_busy;
    assign sts.scan_last = (OCW'(i_reg) == ocnt_reg - 1'b1);
    assign sts.jump_hit  = pt_dist >= r_reg;
    assign sts.j_end     = j_reg >= maxi;
    assign sts.small_r   = (r_reg < accr_reg) && (pcnt_reg != PCW'(2));
    assign sts.box_hit   = (obx_q_reg >= lx) && (obx_q_reg <= hx)
                        && (oby_q_reg >= ly) && (oby_q_reg <= hy);
    assign sts.ev_accept = ev_ge && ev_gt;
    assign sts.s_last    = (s_reg == SW'(SHIFT_TRIES - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.done_flag = done_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while full");

    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.error) |-> m_data_reg.last_bubble)
        else $error("error result not marked last");

    a_sqrt_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sq_start |=> sq_busy)
        else $error("root unit did not start");

endmodule

/* design/psb_ctrl.sv */
// ----------------------------------------------------------------------------
// psb_ctrl
// Sequencer for loads, nearest-obstacle scans, path jumps and bubble shifts.
// ----------------------------------------------------------------------------
module psb_ctrl
    import psb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] operation,
    output logic       s_ready,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ERR   = 5'd1;
    localparam logic [4:0] ST_PRD   = 5'd2;
    localparam logic [4:0] ST_PLAT  = 5'd3;
    localparam logic [4:0] ST_NRD   = 5'd4;
    localparam logic [4:0] ST_DLD   = 5'd5;
    localparam logic [4:0] ST_DMX   = 5'd6;
    localparam logic [4:0] ST_DMY   = 5'd7;
    localparam logic [4:0] ST_DADD  = 5'd8;
    localparam logic [4:0] ST_DSQ   = 5'd9;
    localparam logic [4:0] ST_DRES  = 5'd10;
    localparam logic [4:0] ST_CLAMP = 5'd11;
    localparam logic [4:0] ST_JCHK  = 5'd12;
    localparam logic [4:0] ST_JRD   = 5'd13;
    localparam logic [4:0] ST_SCHK  = 5'd14;
    localparam logic [4:0] ST_SRD   = 5'd15;
    localparam logic [4:0] ST_SLAT  = 5'd16;
    localparam logic [4:0] ST_SDX   = 5'd17;
    localparam logic [4:0] ST_SDY   = 5'd18;
    localparam logic [4:0] ST_SDD   = 5'd19;
    localparam logic [4:0] ST_STEP  = 5'd20;
    localparam logic [4:0] ST_BRD   = 5'd21;
    localparam logic [4:0] ST_BCHK  = 5'd22;
    localparam logic [4:0] ST_TLD   = 5'd23;
    localparam logic [4:0] ST_EVAL  = 5'd24;
    localparam logic [4:0] ST_EMIT  = 5'd25;

    logic [4:0] state_reg, state_next;
    logic       jump_reg, jump_next;    // distance feeds the path jump
    logic       shift_reg, shift_next;  // nearest scan is for a shifted centre

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        jump_next  = jump_reg;
        shift_next = shift_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (operation)
                        OP_LOAD_OBST: cmd.ld_obst = 1'b1;
                        OP_LOAD_PATH: cmd.ld_path = 1'b1;
                        OP_START: begin
                            cmd.walk_init = 1'b1;
                            state_next    = sts.empty ? ST_ERR : ST_PRD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_err  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PRD: state_next = ST_PLAT;
            ST_PLAT: begin
                cmd.p_latch  = 1'b1;
                cmd.scan_clr = 1'b1;
                jump_next    = 1'b0;
                shift_next   = 1'b0;
                state_next   = ST_NRD;
            end
            ST_NRD: state_next = ST_DLD;
            ST_DLD: begin
                cmd.d_load     = 1'b1;
                cmd.d_src_path = jump_reg;
                state_next     = ST_DMX;
            end
            ST_DMX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_UX;
                state_next  = ST_DMY;
            end
            ST_DMY: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_UY;
                cmd.acc_load = 1'b1;
                state_next   = ST_DADD;
            end
            ST_DADD: begin
                cmd.sq_start = 1'b1;
                state_next   = ST_DSQ;
            end
            ST_DSQ: begin
                if (!sts.sq_busy) begin
                    state_next = ST_DRES;
                end
            end
            ST_DRES: begin
                if (jump_reg) begin
                    if (sts.jump_hit) begin
                        cmd.idx_from_j = 1'b1;
                        state_next     = ST_SCHK;
                    end else begin
                        cmd.j_inc  = 1'b1;
                        state_next = ST_JCHK;
                    end
                end else begin
                    cmd.near_upd = 1'b1;
                    cmd.scan_inc = 1'b1;
                    if (sts.scan_last) begin
                        state_next = shift_reg ? ST_TLD : ST_CLAMP;
                    end else begin
                        state_next = ST_NRD;
                    end
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                jump_next  = 1'b1;
                state_next = ST_JCHK;
            end
            ST_JCHK: begin
                if (sts.j_end) begin
                    cmd.idx_max = 1'b1;
                    state_next  = ST_SCHK;
                end else begin
                    state_next = ST_JRD;
                end
            end
            ST_JRD: begin
                cmd.path_sel_j = 1'b1;
                state_next     = ST_DLD;
            end
            ST_SCHK: begin
                jump_next  = 1'b0;
                state_next = sts.small_r ? ST_SRD : ST_EMIT;
            end
            ST_SRD: begin
                cmd.obst_sel_k = 1'b1;
                state_next     = ST_SLAT;
            end
            ST_SLAT: begin
                cmd.div_load = 1'b1;
                state_next   = ST_SDX;
            end
            ST_SDX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                state_next  = ST_SDY;
            end
            ST_SDY: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DY;
                cmd.ddx_load = 1'b1;
                state_next   = ST_SDD;
            end
            ST_SDD: begin
                cmd.ddy_load   = 1'b1;
                cmd.shift_init = 1'b1;
                shift_next     = 1'b1;
                state_next     = ST_STEP;
            end
            ST_STEP: begin
                cmd.step     = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = ST_BRD;
            end
            ST_BRD: state_next = ST_BCHK;
            ST_BCHK: begin
                cmd.scan_inc = 1'b1;
                if (sts.box_hit) begin
                    state_next = ST_EVAL;
                end else if (sts.scan_last) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_NRD;
                end else begin
                    state_next = ST_BRD;
                end
            end
            ST_TLD: begin
                cmd.trial_load = 1'b1;
                state_next     = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.ev_accept || sts.s_last) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.done_flag ? ST_IDLE : ST_PRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            jump_reg  <= 1'b0;
            shift_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            jump_reg  <= jump_next;
            shift_reg <= shift_next;
        end
    end

    a_idle_root_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.sq_busy)
        else $error("root unit busy while idle");

    a_emit_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && sts.out_free) |=>
            (state_reg == ST_IDLE || state_reg == ST_PRD))
        else $error("bubble result not followed by next point or idle");

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> $past(cmd.out_load))
        else $error("returned to idle without a result");

endmodule

/* tb/sv/path_safety_bubble_generator_test.sv */
// ----------------------------------------------------------------------------
// path_safety_bubble_generator_test
// Self-checking bench for the path safety bubble generator.
// ----------------------------------------------------------------------------
// Input beats (loads, starts, unused codes) are queued by the stimulus process and sent by a
// driver with random gaps. A scoreboard mirrors the obstacle and path stores,
// walks the path on every accepted start and queues the bubbles it expects.
// The monitor compares each result beat field by field with the oldest one.
// Register settings cover both extremes of both radius limits.
// ----------------------------------------------------------------------------
module path_safety_bubble_generator_test;
    import psb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int OBST_CAP   = 256;
    localparam int PATH_CAP   = 64;
    localparam int TRIES      = 10;
    localparam int OBST_LIMIT = 20;
    localparam longint CYCLE_LIMIT = 40000000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RAD_W-1:0]     cfg_wdata = '0;

    path_safety_bubble_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    in_item_t  beat_q[$];
    out_item_t bubble_q[$];
    int        errors = 0;
    int        snd_idle = 25;
    int        rcv_idle = 65;
    int        hold_cnt = 0;
    int        gen_obst = 0;
    logic      in_taken = 1'b0;
    longint    cycles = 0;

    // scoreboard copy of the block's stores and registers
    longint          obst_x[OBST_CAP];
    longint          obst_y[OBST_CAP];
    longint          path_x[PATH_CAP];
    longint          path_y[PATH_CAP];
    int              n_obst = 0;
    int              n_path = 0;
    longint unsigned lim_max = 64'd131072;
    longint unsigned lim_acc = 64'd32768;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span(longint ax, longint ay, longint bx, longint by);
        longint          dx, dy;
        longint unsigned ux, uy, s;
        dx = ax - bx;
        dy = ay - by;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) return 64'h7FFF_FFFF;
        s = root64(ux * ux + uy * uy);
        return s > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : s;
    endfunction

    function automatic longint unsigned nearest_obst(longint px, longint py, output int which);
        longint unsigned best, d;
        best = 0;
        which = 0;
        for (int i = 0; i < n_obst; i++) begin
            d = span(px, py, obst_x[i], obst_y[i]);
            if (i == 0 || d < best) begin
                best = d;
                which = i;
            end
        end
        return best;
    endfunction

    function automatic bit box_blocked(longint ax, longint ay, longint bx, longint by);
        longint lx, hx, ly, hy;
        lx = ax < bx ? ax : bx;
        hx = ax < bx ? bx : ax;
        ly = ay < by ? ay : by;
        hy = ay < by ? by : ay;
        for (int i = 0; i < n_obst; i++)
            if (obst_x[i] >= lx && obst_x[i] <= hx && obst_y[i] >= ly && obst_y[i] <= hy)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_bubble(longint cx, longint cy, longint unsigned rad,
                                        bit last, bit err);
        out_item_t e;
        e.center_x    = cx[31:0];
        e.center_y    = cy[31:0];
        e.radius      = rad[30:0];
        e.last_bubble = last;
        e.error       = err;
        bubble_q = {bubble_q, e};
    endfunction

    function automatic void walk_path();
        int              idx, maxi, j, k, kk, n;
        bit              edge_run, done;
        longint          px, py, cx, cy, ddx, ddy, nx, ny;
        longint unsigned r, rad, trial, best;
        if (n_obst == 0 || n_path == 0) begin
            push_bubble(0, 0, 0, 1'b1, 1'b1);
            return;
        end
        maxi = n_path - 1;
        edge_run = (n_path == 2);
        idx = 0;
        done = 1'b0;
        n = 0;
        while (!done && n < PATH_CAP) begin
            px = path_x[idx];
            py = path_y[idx];
            cx = px;
            cy = py;
            j = idx;
            if (idx == maxi) done = 1'b1;
            r = nearest_obst(px, py, k);
            if (r > lim_max) r = lim_max;
            rad = r;
            // jump to the first later point outside the bubble
            while (1) begin
                j++;
                if (j >= maxi) begin
                    idx = maxi;
                    break;
                end
                if (span(path_x[j], path_y[j], px, py) >= r) begin
                    idx = j;
                    break;
                end
            end
            if (r < lim_acc && !edge_run) begin
                ddx = (px - obst_x[k]) / 5;
                ddy = (py - obst_y[k]) / 5;
                nx = px;
                ny = py;
                trial = 0;
                best = 0;
                for (int s = 0; s < TRIES; s++) begin
                    nx = sat32(nx + ddx);
                    ny = sat32(ny + ddy);
                    if (!box_blocked(px, py, nx, ny)) trial = nearest_obst(nx, ny, kk);
                    if (trial >= best) begin
                        best = trial;
                        if (trial > lim_acc) begin
                            rad = trial;
                            cx = nx;
                            cy = ny;
                            break;
                        end
                    end
                end
            end
            push_bubble(cx, cy, rad, done, 1'b0);
            n++;
        end
    endfunction

    function automatic void predict_beat(in_item_t b);
        case (b.operation)
            OP_LOAD_OBST: begin
                if (n_obst < OBST_CAP) begin
                    obst_x[n_obst] = longint'(b.coord_x);
                    obst_y[n_obst] = longint'(b.coord_y);
                    n_obst++;
                end
            end
            OP_LOAD_PATH: begin
                if (n_path < PATH_CAP) begin
                    path_x[n_path] = longint'(b.coord_x);
                    path_y[n_path] = longint'(b.coord_y);
                    n_path++;
                end
            end
            OP_START: walk_path();
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // input side: sample accepts, run the scoreboard, check results
    always @(posedge aclk) begin
        out_item_t w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end else begin
            in_taken <= s_valid && s_ready && aresetn;
            if (aresetn && s_valid && s_ready) predict_beat(s_data);
            if (aresetn && m_valid && m_ready) begin
                if (bubble_q.size() == 0) begin
                    report_mismatch("unexpected bubble", m_data.radius, 0);
                end else begin
                    w = bubble_q.pop_front();
                    if (m_data.center_x != w.center_x)
                        report_mismatch("center_x", m_data.center_x, w.center_x);
                    if (m_data.center_y != w.center_y)
                        report_mismatch("center_y", m_data.center_y, w.center_y);
                    if (m_data.radius != w.radius)
                        report_mismatch("radius", m_data.radius, w.radius);
                    if (m_data.last_bubble != w.last_bubble)
                        report_mismatch("last_bubble", m_data.last_bubble, w.last_bubble);
                    if (m_data.error != w.error)
                        report_mismatch("error", m_data.error, w.error);
                end
            end
        end
    end

    // sender
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (beat_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
                s_valid <= 1'b1;
                s_data  <= beat_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    function automatic in_item_t mk_beat(logic [1:0] op, logic signed [31:0] x,
                                         logic signed [31:0] y);
        in_item_t b;
        b.operation = op;
        b.coord_x   = x;
        b.coord_y   = y;
        if (op == OP_LOAD_OBST) gen_obst++;
        return b;
    endfunction

    function automatic void queue_beat(in_item_t b);
        beat_q = {beat_q, b};
    endfunction

    // mostly within 262144 of the origin, sometimes anywhere
    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 524288) - 262144;
    endfunction

    task automatic drain();
        while (beat_q.size() > 0 || s_valid || bubble_q.size() > 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_RADIUS) lim_max = val;
        else lim_acc = val;
    endtask

    task automatic run_phase(int n_items, int n_starts);
        int made, starts, cnt;
        made = 0;
        starts = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_beat(mk_beat(OP_UNUSED, $urandom, $urandom));
                made++;
            end else begin
                cnt = (gen_obst < OBST_LIMIT) ? $urandom_range(0, 2) : 0;
                repeat (cnt) queue_beat(mk_beat(OP_LOAD_OBST, rand_coord(), rand_coord()));
                cnt = $urandom_range(1, 3);
                repeat (cnt) queue_beat(mk_beat(OP_LOAD_PATH, rand_coord(), rand_coord()));
                made += cnt + 1;
                if (starts < n_starts && $urandom_range(0, 3) == 0) begin
                    queue_beat(mk_beat(OP_START, $urandom, $urandom));
                    starts++;
                end
            end
        end
        if (starts == 0) queue_beat(mk_beat(OP_START, 0, 0));
        drain();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty stores, single point, two points, extremes, ties
        queue_beat(mk_beat(OP_START, 0, 0));
        queue_beat(mk_beat(OP_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000));
        queue_beat(mk_beat(OP_LOAD_PATH, 0, 0));
        queue_beat(mk_beat(OP_START, 0, 0));
        queue_beat(mk_beat(OP_LOAD_OBST, 16384, 0));
        queue_beat(mk_beat(OP_START, 0, 0));
        queue_beat(mk_beat(OP_LOAD_PATH, 196608, 0));
        queue_beat(mk_beat(OP_START, 0, 0));
        queue_beat(mk_beat(OP_LOAD_OBST, -16384, 0));
        queue_beat(mk_beat(OP_LOAD_PATH, 32'h7FFF_FFFF, 32'h8000_0000));
        queue_beat(mk_beat(OP_LOAD_OBST, 32'h8000_0000, 32'h7FFF_FFFF));
        queue_beat(mk_beat(OP_START, 0, 0));
        drain();
        write_reg(REG_MAX_RADIUS, RADIUS_SAT);
        write_reg(REG_ACC_RADIUS, RADIUS_SAT);
        queue_beat(mk_beat(OP_LOAD_PATH, 65536, 65536));
        queue_beat(mk_beat(OP_START, 0, 0));
        drain();

        // random phases, the first opening with a start under a long hold-off
        write_reg(REG_MAX_RADIUS, MAX_RADIUS_RST);
        write_reg(REG_ACC_RADIUS, ACC_RADIUS_RST);
        hold_cnt = 3000;
        queue_beat(mk_beat(OP_START, 0, 0));
        run_phase(20, 3);
        snd_idle = 65;
        rcv_idle = 25;
        write_reg(REG_MAX_RADIUS, '0);
        write_reg(REG_ACC_RADIUS, '0);
        run_phase(20, 3);
        snd_idle = 0;
        rcv_idle = 0;
        write_reg(REG_MAX_RADIUS, RADIUS_SAT);
        write_reg(REG_ACC_RADIUS, 31'd196608);
        run_phase(20, 2);

        // obstacle store overflow, then one walk over the full store
        write_reg(REG_ACC_RADIUS, '0);
        while (gen_obst < OBST_CAP + 4)
            queue_beat(mk_beat(OP_LOAD_OBST, $urandom, $urandom));
        queue_beat(mk_beat(OP_START, 0, 0));
        drain();

        if (errors == 0 && bubble_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/psb_pkg.sv
design/psb_isqrt.sv
design/psb_datapath.sv
design/psb_ctrl.sv
design/path_safety_bubble_generator.sv
tb/sv/path_safety_bubble_generator_test.sv
